@@ design/spiram_pkg.sv @@
// ----------------------------------------------------------------------------
// spiram_pkg
// Shared types and constants of the SPI register access master.
// ----------------------------------------------------------------------------
package spiram_pkg;

  localparam int unsigned MaxBurst   = 64;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [1:0] FuncRequest = 2'd0;
  localparam logic [1:0] FuncData    = 2'd1;
  localparam logic [1:0] FuncTick    = 2'd2;

  localparam logic [7:0] AddrMask  = 8'b0111_1110;
  localparam logic [7:0] ReadFlag  = 8'b1000_0000;
  localparam logic [7:0] FullMask  = 8'b1111_1111;

  typedef enum logic [1:0] {
    CmdRequest,
    CmdData,
    CmdTick,
    CmdNone
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e             kind;
    logic                  req_read;
    logic [7:0]            addr_byte;
    logic [CountWidth-1:0] count;
    logic [2:0]            align;
    logic [7:0]            wr_data;
    logic                  miso;
  } cmd_t;

  typedef struct packed {
    logic       sclk;
    logic       mosi;
    logic       cs_n;
    logic [7:0] rd_data;
    logic       rd_valid;
    logic       rd_last;
    logic [7:0] rd_keep_mask;
    logic       need_data;
    logic       busy_res;
    logic       error;
  } res_t;

endpackage

@@ design/spiram_front.sv @@
// ----------------------------------------------------------------------------
// spiram_front
// Decodes an input word into a command: kind, clamped burst count and the
// address byte that goes out on the wire.
// ----------------------------------------------------------------------------
module spiram_front import spiram_pkg::*; (
  input  logic [1:0]            func_i,
  input  logic                  req_read_i,
  input  logic [5:0]            reg_address_i,
  input  logic [CountWidth-1:0] burst_count_i,
  input  logic [2:0]            rx_align_i,
  input  logic [7:0]            wr_data_i,
  input  logic                  miso_i,
  output cmd_t                  cmd_o
);

  logic [CountWidth-1:0] count;

  always_comb begin
    if (burst_count_i == '0) begin
      count = CountWidth'(1);
    end else if (burst_count_i > CountWidth'(MaxBurst)) begin
      count = CountWidth'(MaxBurst);
    end else begin
      count = burst_count_i;
    end
  end

  always_comb begin
    case (func_i)
      FuncRequest: cmd_o.kind = CmdRequest;
      FuncData:    cmd_o.kind = CmdData;
      FuncTick:    cmd_o.kind = CmdTick;
      default:     cmd_o.kind = CmdNone;
    endcase
    cmd_o.req_read  = req_read_i;
    cmd_o.addr_byte = ({1'b0, reg_address_i, 1'b0} & AddrMask) |
                      (req_read_i ? ReadFlag : 8'h00);
    cmd_o.count     = count;
    cmd_o.align     = rx_align_i;
    cmd_o.wr_data   = wr_data_i;
    cmd_o.miso      = miso_i;
  end

endmodule

@@ design/spiram_queue.sv @@
// ----------------------------------------------------------------------------
// spiram_queue
// Short command queue between the decoder and the serial engine.
// ----------------------------------------------------------------------------
module spiram_queue import spiram_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ design/spiram_back.sv @@
// ----------------------------------------------------------------------------
// spiram_back
// Serial engine: runs the SPI sequencer one command per cycle while the output
// register is free or being taken, and holds the result word in that register.
// ----------------------------------------------------------------------------
module spiram_back import spiram_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  output res_t res_o,
  output logic res_valid_o,
  input  logic res_ready_i
);

  typedef enum logic [2:0] {
    PhIdle,
    PhAddr,
    PhWait,
    PhWrite,
    PhRead
  } phase_e;

  phase_e                ph_q, ph_d;
  logic [7:0]            tx_q, tx_d;
  logic [7:0]            rx_q, rx_d;
  logic [2:0]            bit_q, bit_d;
  logic [CountWidth-1:0] left_q, left_d;
  logic [CountWidth-1:0] left_dec;
  logic                  clk_q, clk_d;
  logic [7:0]            held_addr_q, held_addr_d;
  logic [2:0]            held_align_q, held_align_d;
  logic                  first_q, first_d;
  logic                  is_read_q, is_read_d;
  res_t                  res_q, res_d;
  logic                  res_valid_q;
  logic                  step;

  assign step      = cmd_valid_i && (!res_valid_q || res_ready_i);
  assign cmd_pop_o = step;
  assign left_dec  = left_q - 1'b1;

  always_comb begin
    ph_d         = ph_q;
    tx_d         = tx_q;
    rx_d         = rx_q;
    bit_d        = bit_q;
    left_d       = left_q;
    clk_d        = clk_q;
    held_addr_d  = held_addr_q;
    held_align_d = held_align_q;
    first_d      = first_q;
    is_read_d    = is_read_q;
    res_d        = '0;

    case (cmd_i.kind)
      CmdRequest: begin
        if (ph_q != PhIdle) begin
          res_d.error = 1'b1;
        end else begin
          left_d       = cmd_i.count;
          is_read_d    = cmd_i.req_read;
          held_addr_d  = cmd_i.addr_byte;
          held_align_d = cmd_i.align;
          first_d      = 1'b1;
          clk_d        = 1'b0;
          tx_d         = cmd_i.addr_byte;
          rx_d         = '0;
          bit_d        = '0;
          ph_d         = PhAddr;
        end
      end
      CmdData: begin
        if (ph_q == PhWait) begin
          left_d = left_dec;
          tx_d   = cmd_i.wr_data;
          rx_d   = '0;
          bit_d  = '0;
          ph_d   = PhWrite;
        end else begin
          res_d.error = 1'b1;
        end
      end
      CmdTick: begin
        if (ph_q inside {PhAddr, PhWrite, PhRead}) begin
          if (!clk_q) begin
            clk_d = 1'b1;
            if (ph_q == PhRead) begin
              rx_d = {rx_q[6:0], cmd_i.miso};
            end
          end else begin
            clk_d = 1'b0;
            tx_d  = {tx_q[6:0], 1'b0};
            if (bit_q != 3'd7) begin
              bit_d = bit_q + 1'b1;
            end else begin
              bit_d = '0;
              case (ph_q)
                PhAddr: begin
                  if (is_read_q) begin
                    tx_d = (left_q > CountWidth'(1)) ? held_addr_q : 8'h00;
                    rx_d = '0;
                    ph_d = PhRead;
                  end else begin
                    ph_d = PhWait;
                  end
                end
                PhWrite: begin
                  ph_d = (left_q != '0) ? PhWait : PhIdle;
                end
                default: begin
                  res_d.rd_data      = rx_q;
                  res_d.rd_valid     = 1'b1;
                  res_d.rd_keep_mask = first_q ? (FullMask << held_align_q) : FullMask;
                  first_d            = 1'b0;
                  left_d             = left_dec;
                  if (left_dec == '0) begin
                    res_d.rd_last = 1'b1;
                    ph_d          = PhIdle;
                  end else begin
                    tx_d = (left_dec > CountWidth'(1)) ? held_addr_q : 8'h00;
                    rx_d = '0;
                  end
                end
              endcase
            end
          end
        end
      end
      default: begin
      end
    endcase

    res_d.sclk      = clk_d;
    res_d.mosi      = tx_d[7];
    res_d.cs_n      = (ph_d == PhIdle);
    res_d.need_data = (ph_d == PhWait);
    res_d.busy_res  = (ph_d != PhIdle);
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q         <= PhIdle;
      tx_q         <= '0;
      rx_q         <= '0;
      bit_q        <= '0;
      left_q       <= '0;
      clk_q        <= 1'b0;
      held_addr_q  <= '0;
      held_align_q <= '0;
      first_q      <= 1'b1;
      is_read_q    <= 1'b0;
      res_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (step) begin
        ph_q         <= ph_d;
        tx_q         <= tx_d;
        rx_q         <= rx_d;
        bit_q        <= bit_d;
        left_q       <= left_d;
        clk_q        <= clk_d;
        held_addr_q  <= held_addr_d;
        held_align_q <= held_align_d;
        first_q      <= first_d;
        is_read_q    <= is_read_d;
        res_q        <= res_d;
        res_valid_q  <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ design/spi_register_access_master_unit.sv @@
// ----------------------------------------------------------------------------
// spi_register_access_master_unit
// SPI mode 0 register access master with stream ports.
// ----------------------------------------------------------------------------
// Each input word is a request, a write data byte, one SCLK half-period tick
// or a no-op, and gives exactly one result word with the pin levels and status.
// The block takes one word per clock cycle while the command queue is not full;
// a word's result passes through the two-entry command queue and the engine's
// output register before it is presented. Backpressure on the result side
// fills the queue, after which s_axis_tready drops.
module spi_register_access_master_unit import spiram_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // reg_address[5:0], burst_count[12:6], rx_align[15:13], wr_data[23:16],
  // miso[24], zero fill [31:25]
  input  logic [31:0] s_axis_tdata,
  // func[1:0], req_read[2]
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // sclk[0], mosi[1], cs_n[2], rd_data[10:3], rd_valid[11],
  // rd_keep_mask[19:12], need_data[20], busy_res[21], error[22], zero [23]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  cmd_t cmd_in;
  cmd_t cmd_head;
  res_t res;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic push;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  spiram_front u_front (
    .func_i        (s_axis_tuser[1:0]),
    .req_read_i    (s_axis_tuser[2]),
    .reg_address_i (s_axis_tdata[5:0]),
    .burst_count_i (s_axis_tdata[12:6]),
    .rx_align_i    (s_axis_tdata[15:13]),
    .wr_data_i     (s_axis_tdata[23:16]),
    .miso_i        (s_axis_tdata[24]),
    .cmd_o         (cmd_in)
  );

  spiram_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (cmd_in),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .head_o     (cmd_head),
    .empty_o    (q_empty)
  );

  spiram_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_valid_i (!q_empty),
    .cmd_pop_o   (q_pop),
    .res_o       (res),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, res.error, res.busy_res, res.need_data, res.rd_keep_mask,
                         res.rd_valid, res.rd_data, res.cs_n, res.mosi, res.sclk};
  assign m_axis_tlast = res.rd_last;

endmodule
